// ===== hw/rtl/polar_go_to_goal_controller_top_macros.svh =====
// Assertion macros used by the controller checker.
`ifndef POLAR_GO_TO_GOAL_CONTROLLER_TOP_MACROS_SVH
`define POLAR_GO_TO_GOAL_CONTROLLER_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PGG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define PGG_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/pgg_pkg.sv =====
// Types, constants and helper functions of the polar go-to-goal controller.
package pgg_pkg;

	localparam int CORDIC_STEPS  = 16;
	localparam int POSITION_BITS = 32;

	localparam int PB_IN     = (POSITION_BITS < 32) ? POSITION_BITS : 32;
	localparam int XY_W      = POSITION_BITS + 4;
	localparam int Z_W       = 20;
	localparam int ANG_W     = 16;
	localparam int BEAR_W    = Z_W - 3;
	localparam int WRAP_W    = 19;
	localparam int STEP_W    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int ATAN_IDX_W = 5;
	localparam int DIST_W    = XY_W;
	localparam int SPROD_W   = DIST_W + 15;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	// start edge to the edge that takes the result
	localparam int LATENCY   = CORDIC_STEPS + 5;

	localparam logic signed [WRAP_W-1:0] W_PI     = WRAP_W'(25736);
	localparam logic signed [WRAP_W-1:0] W_TWO_PI = WRAP_W'(51472);
	localparam logic signed [Z_W-1:0]    Z_PI     = Z_W'(205887);
	localparam logic [15:0]              INV_GAIN = 16'd39797;
	localparam logic [30:0]              SPEED_MAX = 31'h7FFF_FFFF;
	localparam logic [63:0]              DIST_CLAMP = 64'd1 << 44;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BEARING_GAIN       = 3'd0,
		REG_FINAL_HEADING_GAIN = 3'd1,
		REG_DISTANCE_GAIN      = 3'd2,
		REG_SPEED_THRESHOLD    = 3'd3,
		REG_TURN_THRESHOLD     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] robot_x;
		logic signed [31:0] robot_y;
		logic signed [15:0] robot_heading;
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
		logic signed [15:0] goal_heading;
	} cmd_t;

	typedef struct packed {
		logic               arrived;
		logic signed [31:0] turn_rate;
		logic [30:0]        forward_speed;
	} result_t;

	typedef struct packed {
		logic signed [15:0] bearing_gain;
		logic signed [15:0] final_heading_gain;
		logic [14:0]        distance_gain;
		logic [30:0]        speed_threshold;
		logic [30:0]        turn_threshold;
	} gains_t;

	// data handed from cell to cell
	typedef struct packed {
		logic                    zero;
		logic signed [XY_W-1:0]  x;
		logic signed [XY_W-1:0]  y;
		logic signed [Z_W-1:0]   z;
		logic signed [ANG_W-1:0] rh;
		logic signed [ANG_W-1:0] gh;
	} cordic_t;

	// arctangent of 2^-i in Q.16 rad, rounded; zero from step 17 on
	function automatic logic signed [Z_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] i);
		logic signed [Z_W-1:0] r;
		case (i)
			5'd0:    r = Z_W'(51472);
			5'd1:    r = Z_W'(30386);
			5'd2:    r = Z_W'(16055);
			5'd3:    r = Z_W'(8150);
			5'd4:    r = Z_W'(4091);
			5'd5:    r = Z_W'(2047);
			5'd6:    r = Z_W'(1024);
			5'd7:    r = Z_W'(512);
			5'd8:    r = Z_W'(256);
			5'd9:    r = Z_W'(128);
			5'd10:   r = Z_W'(64);
			5'd11:   r = Z_W'(32);
			5'd12:   r = Z_W'(16);
			5'd13:   r = Z_W'(8);
			5'd14:   r = Z_W'(4);
			5'd15:   r = Z_W'(2);
			5'd16:   r = Z_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

	// position as two's complement of POSITION_BITS bits, widened
	function automatic logic signed [XY_W-1:0] sext_pos(input logic [31:0] v);
		logic signed [31:0] t;
		t = $signed(v << (32 - PB_IN)) >>> (32 - PB_IN);
		return XY_W'(t);
	endfunction

	// fold into [-pi, pi]; two passes cover every reachable value
	function automatic logic signed [WRAP_W-1:0] wrap_angle(input logic signed [WRAP_W-1:0] a);
		logic signed [WRAP_W-1:0] r;
		r = a;
		for (int k = 0; k < 2; k++) begin
			if (r > W_PI) begin
				r = r - W_TWO_PI;
			end else if (r < -W_PI) begin
				r = r + W_TWO_PI;
			end
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/pgg_cordic_cell.sv =====
// One vectoring CORDIC cell: a single micro-rotation and its pipeline register.
module pgg_cordic_cell import pgg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [STEP_W-1:0] step,
	input  logic              in_valid,
	input  cordic_t           din,
	output logic              out_valid,
	output cordic_t           dout
);

	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0]  ang;
	cordic_t                nxt;
	logic                   valid_s1;
	cordic_t                data_s1;

	always_comb begin
		xs  = $signed(din.x) >>> step;
		ys  = $signed(din.y) >>> step;
		ang = atan_q16(ATAN_IDX_W'(step));
		nxt = din;
		if (!din.y[XY_W-1]) begin
			nxt.x = din.x + ys;
			nxt.y = din.y - xs;
			nxt.z = din.z + ang;
		end else begin
			nxt.x = din.x - ys;
			nxt.y = din.y + xs;
			nxt.z = din.z - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

	assign out_valid = valid_s1;
	assign dout      = data_s1;

endmodule

// ===== hw/rtl/pgg_post.sv =====
// Back end: bearing, angle wrap, gain multiplies, saturation and arrival test.
module pgg_post import pgg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  cordic_t din,
	input  gains_t  gains,
	output logic    done,
	output result_t result
);

	// stage 1: bearing, wrapped angles, distance partial products
	logic signed [Z_W-1:0]    z_rnd;
	logic signed [BEAR_W-1:0] bearing;
	logic signed [WRAP_W-1:0] alpha_w;
	logic signed [WRAP_W-1:0] beta_w;
	logic [XY_W-1:0]          xpos;
	logic [XY_W-1:0]          hi_prod;
	logic [31:0]              lo_prod;

	logic                     valid_s1;
	logic signed [ANG_W-1:0]  alpha_s1;
	logic signed [ANG_W-1:0]  beta_s1;
	logic [XY_W-1:0]          dist_hi_s1;
	logic [15:0]              dist_lo_s1;

	// stage 2: rate products, full distance
	logic [DIST_W-1:0]        dist_sum;
	logic [DIST_W-1:0]        dist_clamped;
	logic                     valid_s2;
	logic signed [31:0]       prod_a_s2;
	logic signed [31:0]       prod_b_s2;
	logic [DIST_W-1:0]        dist_s2;

	// stage 3: rate, speed product
	logic signed [32:0]       rate_sum;
	logic                     valid_s3;
	logic signed [31:0]       rate_s3;
	logic [SPROD_W-1:0]       sprod_s3;

	// stage 4: saturation and arrival
	logic [SPROD_W-13:0]      speed_sh;
	logic [30:0]              speed;
	logic [31:0]              mag;
	logic                     valid_s4;
	result_t                  result_s4;

	always_comb begin
		z_rnd   = $signed(din.z) + Z_W'(4);
		bearing = din.zero ? '0 : BEAR_W'(z_rnd >>> 3);
		alpha_w = wrap_angle(WRAP_W'(bearing) - WRAP_W'($signed(din.rh)));
		beta_w  = wrap_angle(WRAP_W'($signed(din.gh)) - WRAP_W'(bearing));
		xpos    = din.x[XY_W-1] ? '0 : XY_W'(din.x);
		hi_prod = XY_W'(xpos[XY_W-1:16]) * XY_W'(INV_GAIN);
		lo_prod = 32'(xpos[15:0]) * 32'(INV_GAIN);
	end

	always_comb begin
		dist_sum     = dist_hi_s1 + DIST_W'(dist_lo_s1);
		dist_clamped = (64'(dist_sum) > DIST_CLAMP) ? DIST_W'(DIST_CLAMP) : dist_sum;
	end

	// |rate| stays far inside 32 bits, so sign extension is the saturation
	always_comb begin
		rate_sum = 33'(prod_a_s2) + 33'(prod_b_s2);
	end

	always_comb begin
		speed_sh = sprod_s3[SPROD_W-1:12];
		speed    = (64'(speed_sh) > 64'(SPEED_MAX)) ? SPEED_MAX : 31'(speed_sh);
		mag      = rate_s3[31] ? 32'(-rate_s3) : 32'(rate_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		alpha_s1   <= ANG_W'(alpha_w);
		beta_s1    <= ANG_W'(beta_w);
		dist_hi_s1 <= hi_prod;
		dist_lo_s1 <= lo_prod[31:16];

		prod_a_s2  <= 32'(gains.bearing_gain) * 32'(alpha_s1);
		prod_b_s2  <= 32'(gains.final_heading_gain) * 32'(beta_s1);
		dist_s2    <= dist_clamped;

		rate_s3    <= 32'(rate_sum >>> 9);
		sprod_s3   <= SPROD_W'(dist_s2) * SPROD_W'(gains.distance_gain);

		result_s4.turn_rate     <= rate_s3;
		result_s4.forward_speed <= speed;
		result_s4.arrived       <= (speed < gains.speed_threshold) &&
		                           (mag < {1'b0, gains.turn_threshold});
	end

	assign done   = valid_s4;
	assign result = result_s4;

endmodule

// ===== hw/rtl/polar_go_to_goal_controller_top.sv =====
// Top level of the polar go-to-goal controller: input stage, CORDIC cell row, back end.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+----------------------------------------
//  command   | start, busy             | cmd      (cmd_t: robot pose, goal pose)
//  result    | done (one-cycle strobe) | result   (result_t: arrived, rate, speed)
//  config    | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// A command transaction completes on an edge with start high and busy low; one
// transaction can follow every cycle. Its result is registered through one input
// register, one register per CORDIC cell and four back-end stages (bearing/wrap,
// products, sums, saturation). The chain of cells sets the depth.
// busy and the low cfg_ready last only for the first cycle after reset is released.
// The result side cannot stall: done is a strobe and the result is gone in the cycle after it.
module polar_go_to_goal_controller_top import pgg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cmd_t                  cmd,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic                   busy_q;
	gains_t                 gains_q;
	logic                   accept;

	// input stage: offset and half-plane pre-rotation
	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;
	cordic_t                pre;
	logic                   valid_s0;
	cordic_t                data_s0;

	// row of cells, entry k feeds cell k
	logic                   chain_valid [CORDIC_STEPS+1];
	cordic_t                chain_data  [CORDIC_STEPS+1];

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign cfg_ready = !busy_q;

	// held busy for one cycle after reset release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.bearing_gain       <= 16'sd6554;
			gains_q.final_heading_gain <= -16'sd2048;
			gains_q.distance_gain      <= 15'd2458;
			gains_q.speed_threshold    <= 31'd5243;
			gains_q.turn_threshold     <= 31'd3277;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BEARING_GAIN:       gains_q.bearing_gain       <= $signed(cfg_data[15:0]);
				REG_FINAL_HEADING_GAIN: gains_q.final_heading_gain <= $signed(cfg_data[15:0]);
				REG_DISTANCE_GAIN:      gains_q.distance_gain      <= cfg_data[14:0];
				REG_SPEED_THRESHOLD:    gains_q.speed_threshold    <= cfg_data[30:0];
				REG_TURN_THRESHOLD:     gains_q.turn_threshold     <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// offset to the goal; a left-half-plane vector is turned by pi so the
	// cells only have to cover +-pi/2
	always_comb begin
		dx       = sext_pos(cmd.goal_x) - sext_pos(cmd.robot_x);
		dy       = sext_pos(cmd.goal_y) - sext_pos(cmd.robot_y);
		pre.zero = (dx == '0) && (dy == '0);
		pre.rh   = cmd.robot_heading;
		pre.gh   = cmd.goal_heading;
		if (dx[XY_W-1]) begin
			pre.x = -dx;
			pre.y = -dy;
			pre.z = dy[XY_W-1] ? -Z_PI : Z_PI;
		end else begin
			pre.x = dx;
			pre.y = dy;
			pre.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		data_s0 <= pre;
	end

	assign chain_valid[0] = valid_s0;
	assign chain_data[0]  = data_s0;

	// one micro-rotation per cell, step number tied per position
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
		pgg_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (STEP_W'(k)),
			.in_valid  (chain_valid[k]),
			.din       (chain_data[k]),
			.out_valid (chain_valid[k+1]),
			.dout      (chain_data[k+1])
		);
	end

	// bearing, angle errors, gains, saturation, arrival flag
	pgg_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_valid[CORDIC_STEPS]),
		.din      (chain_data[CORDIC_STEPS]),
		.gains    (gains_q),
		.done     (done),
		.result   (result)
	);

endmodule

// ===== hw/rtl/pgg_checker.sv =====
// Port-level checker for the controller, bound to the top level.
`include "polar_go_to_goal_controller_top_macros.svh"

module pgg_checker import pgg_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// every accepted command gives its result after the fixed pipeline depth
	`PGG_ASSERT(a_result_follows, (start && !busy) |-> ##LATENCY done, "result missing")

	// no result without a command that depth earlier
	`PGG_ASSERT(a_no_spurious, done |-> $past(start && !busy, LATENCY), "stray result")

	// arrival needs a speed below a 31-bit threshold, so never the saturated value
	`PGG_ASSERT_NEVER(a_arrived_speed, done && result.arrived && (result.forward_speed == SPEED_MAX), "arrived at max speed")

	// once free after reset, busy stays low
	`PGG_ASSERT(a_busy_short, !busy |=> !busy, "busy raised after reset")

endmodule

bind polar_go_to_goal_controller_top pgg_checker u_pgg_checker (.*);
